// File: rtl/bounded_deque_with_reverse_top_assert.svh
// assertion macros for the deque block checker
// needs clk_i and rst_ni visible in the scope that uses them
`ifndef BOUNDED_DEQUE_WITH_REVERSE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_REVERSE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bdr_pkg.sv
// shared types and constants for the bounded deque block
// no dependencies
package bdr_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int CQ_DEPTH  = 2;
  localparam int OQ_DEPTH  = 4;

  localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_REVERSE  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP     = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_ELEM  = 2'd3;

  typedef enum logic [2:0] {
    CMD_APPEND,
    CMD_REM_HEAD,
    CMD_REM_TAIL,
    CMD_REVERSE,
    CMD_DUMP,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ST_W-1:0]         status;
    logic                    last;
  } res_t;

endpackage

// File: rtl/bdr_fifo.sv
// small register fifo, power-of-two depth, combinational read of the head
// no package dependency
module bdr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [W-1:0]               wdata_i,
  input  logic                       pop_i,
  output logic [W-1:0]               rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH):0]     cnt_o
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/bdr_front.sv
// front end: takes input items, classifies the opcode into a command
// and queues it; uses bdr_pkg and bdr_fifo
module bdr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [bdr_pkg::OP_W-1:0]       opcode_i,
  input  logic signed [bdr_pkg::VAL_W-1:0] value_i,
  output bdr_pkg::cmd_t                  cmd_o,
  output logic                           cmd_valid_o,
  input  logic                           cmd_pop_i
);

  localparam int CMD_W = $bits(bdr_pkg::cmd_t);

  bdr_pkg::cmd_t    cmd_in;
  logic [CMD_W-1:0] cmd_raw;
  logic             cq_empty;
  logic [$clog2(bdr_pkg::CQ_DEPTH):0] cq_cnt;

  always_comb begin
    cmd_in.value = '0;
    unique case (opcode_i)
      bdr_pkg::OP_APPEND: begin
        cmd_in.cmd   = bdr_pkg::CMD_APPEND;
        cmd_in.value = value_i;
      end
      bdr_pkg::OP_REM_HEAD: cmd_in.cmd = bdr_pkg::CMD_REM_HEAD;
      bdr_pkg::OP_REM_TAIL: cmd_in.cmd = bdr_pkg::CMD_REM_TAIL;
      bdr_pkg::OP_REVERSE:  cmd_in.cmd = bdr_pkg::CMD_REVERSE;
      bdr_pkg::OP_DUMP:     cmd_in.cmd = bdr_pkg::CMD_DUMP;
      default:              cmd_in.cmd = bdr_pkg::CMD_NOP;
    endcase
  end

  bdr_fifo #(
    .W     (CMD_W),
    .DEPTH (bdr_pkg::CQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_raw),
    .full_o  (full_o),
    .empty_o (cq_empty),
    .cnt_o   (cq_cnt)
  );

  assign cmd_o       = bdr_pkg::cmd_t'(cmd_raw);
  // occupancy count agrees with the empty flag
  assign cmd_valid_o = !cq_empty && (cq_cnt != '0);

endmodule

// File: rtl/bdr_back.sv
// back end: ring buffer store, front index, count and direction flag;
// carries out queued commands and sequences dumps; uses bdr_pkg
module bdr_back #(
  parameter int DEPTH = bdr_pkg::DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bdr_pkg::cmd_t                        cmd_i,
  input  logic                                 cmd_valid_i,
  output logic                                 cmd_pop_o,
  output bdr_pkg::res_t                        res_o,
  output logic                                 res_push_o,
  input  logic [$clog2(bdr_pkg::OQ_DEPTH):0]   oq_cnt_i
);

  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int OQ_CNT_W = $clog2(bdr_pkg::OQ_DEPTH) + 1;
  localparam int OCC_W    = OQ_CNT_W + 1;

  typedef enum logic {S_RUN, S_DUMP} state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   front_q, front_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               rev_q, rev_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               rd_valid_q, rd_valid_d;
  logic               rd_last_q, rd_last_d;

  logic signed [bdr_pkg::VAL_W-1:0] mem_q [DEPTH];
  logic signed [bdr_pkg::VAL_W-1:0] rdata_q;
  logic               mem_we, rd_en;
  logic [IDX_W-1:0]   waddr, rd_addr;
  logic [OCC_W-1:0]   occ;
  logic               room;
  logic [CNT_W-1:0]   dump_off;
  logic               low_end;

  // physical slot of an offset from the front, offset at most DEPTH
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // reads in flight count against the output queue space
  assign occ  = OCC_W'(oq_cnt_i) + OCC_W'(rd_valid_q);
  assign room = occ < OCC_W'(bdr_pkg::OQ_DEPTH);

  assign dump_off = rev_q ? (count_q - CNT_W'(1) - idx_q) : idx_q;
  assign rd_addr  = slot_of(front_q, dump_off);

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    rev_d      = rev_q;
    idx_d      = idx_q;
    rd_last_d  = rd_last_q;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    waddr      = slot_of(front_q, count_q);
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    low_end    = (cmd_i.cmd == bdr_pkg::CMD_REM_HEAD) == !rev_q;

    if (rd_valid_q) begin
      res_push_o   = 1'b1;
      res_o.value  = rdata_q;
      res_o.status = bdr_pkg::ST_ELEM;
      res_o.last   = rd_last_q;
    end

    unique case (state_q)
      S_RUN: begin
        if (cmd_valid_i && !rd_valid_q && room) begin
          cmd_pop_o    = 1'b1;
          res_push_o   = 1'b1;
          res_o.last   = 1'b1;
          res_o.status = bdr_pkg::ST_DONE;
          case (cmd_i.cmd)
            bdr_pkg::CMD_APPEND: begin
              if (count_q == CNT_W'(DEPTH)) begin
                res_o.status = bdr_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (rev_q) begin
                  front_d = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
                  waddr   = front_d;
                end
              end
            end
            bdr_pkg::CMD_REM_HEAD, bdr_pkg::CMD_REM_TAIL: begin
              if (count_q == '0) begin
                res_o.status = bdr_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
                if (low_end) begin
                  front_d = slot_of(front_q, CNT_W'(1));
                end
              end
            end
            bdr_pkg::CMD_REVERSE: rev_d = !rev_q;
            bdr_pkg::CMD_DUMP: begin
              if (count_q == '0) begin
                res_o.status = bdr_pkg::ST_EMPTY;
              end else begin
                res_push_o = 1'b0;
                idx_d      = '0;
                state_d    = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (room) begin
          rd_en     = 1'b1;
          rd_last_d = (idx_q + CNT_W'(1)) == count_q;
          idx_d     = idx_q + CNT_W'(1);
          if (rd_last_d) begin
            state_d = S_RUN;
          end
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  assign rd_valid_d = rd_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_RUN;
      front_q    <= '0;
      count_q    <= '0;
      rev_q      <= 1'b0;
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      front_q    <= front_d;
      count_q    <= count_d;
      rev_q      <= rev_d;
      idx_q      <= idx_d;
      rd_valid_q <= rd_valid_d;
      rd_last_q  <= rd_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= cmd_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

endmodule

// File: rtl/bounded_deque_with_reverse_top.sv
// top level of the bounded deque with reverse
// uses bdr_pkg, bdr_front, bdr_back and bdr_fifo
//
// Input channel: an item (opcode_i, value_in_i) transfers on a clock edge with
// push high and full low. Result channel: the oldest result sits on
// value_out_o, status_o and last_o while empty is low and transfers on an edge
// with pop high. Every item gives one result with last_o set, except a dump of
// a non-empty list, which gives one result per element, head to tail, with
// last_o on the final one.
// Path: with the execution unit idle, an item passes the command queue and its
// result the result queue; a dump's elements also pass the store read register.
// Throughput: append, remove, reverse and unused opcodes run one per cycle while
// the result queue has room; a dump holds the execution unit until its elements
// are read, one store read per element through the single read port.
// Reset clears the list to empty in natural order, empties both internal
// queues and raises empty; the element store itself is not cleared.
// When the receiver stops popping, the four-entry result queue fills, the
// execution unit halts, the two-entry command queue fills and full rises.
module bounded_deque_with_reverse_top #(
  parameter int DEPTH = bdr_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [bdr_pkg::OP_W-1:0]           opcode_i,
  input  logic signed [bdr_pkg::VAL_W-1:0]   value_in_i,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [bdr_pkg::VAL_W-1:0]   value_out_o,
  output logic [bdr_pkg::ST_W-1:0]           status_o,
  output logic                               last_o
);

  localparam int RES_W = $bits(bdr_pkg::res_t);

  bdr_pkg::cmd_t    cmd;
  logic             cmd_valid, cmd_pop;
  bdr_pkg::res_t    res_in, res_out;
  logic             res_push;
  logic [RES_W-1:0] res_raw;
  logic             oq_full;
  logic [$clog2(bdr_pkg::OQ_DEPTH):0] oq_cnt;

  bdr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .opcode_i    (opcode_i),
    .value_i     (value_in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  bdr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .oq_cnt_i    (oq_cnt)
  );

  // back end only pushes when it has reserved room, so oq_full never drops one
  bdr_fifo #(
    .W     (RES_W),
    .DEPTH (bdr_pkg::OQ_DEPTH)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push && !oq_full),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_raw),
    .full_o  (oq_full),
    .empty_o (empty),
    .cnt_o   (oq_cnt)
  );

  assign res_out     = bdr_pkg::res_t'(res_raw);
  assign value_out_o = res_out.value;
  assign status_o    = res_out.status;
  assign last_o      = res_out.last;

endmodule

// File: rtl/bdr_checker.sv
// port-level checker for the deque block, attached by bind
// uses bdr_pkg and bounded_deque_with_reverse_top_assert.svh
`include "bounded_deque_with_reverse_top_assert.svh"

module bdr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               empty,
  input logic                               pop,
  input logic signed [bdr_pkg::VAL_W-1:0]   value_out_o,
  input logic [bdr_pkg::ST_W-1:0]           status_o,
  input logic                               last_o
);

  // only dump elements carry data
  `BDR_ASSERT_NOW(a_zero_value, !empty && status_o != bdr_pkg::ST_ELEM, value_out_o == '0, "non-element result with data")
  // every non-element result closes its item
  `BDR_ASSERT_NOW(a_single_last, !empty && status_o != bdr_pkg::ST_ELEM, last_o, "non-element result without last")
  // a waiting result is not withdrawn
  `BDR_ASSERT_NEXT(a_hold_valid, !empty && !pop, !empty, "result withdrawn while stalled")
  // a stalled result keeps its value and status
  `BDR_ASSERT_NEXT(a_hold_data, !empty && !pop, $stable(value_out_o) && $stable(status_o), "result changed while stalled")

endmodule

bind bounded_deque_with_reverse_top bdr_checker u_bdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .value_out_o (value_out_o),
  .status_o    (status_o),
  .last_o      (last_o)
);
